// ===== rtl/core/acpe_pkg.sv =====
// Package: cell types, configuration codes and colour helpers for the pixel expander.
`timescale 1ns / 1ps

package acpe_pkg;

    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ORDER = 1'd1;

    localparam logic [7:0] LEVEL_NORMAL = 8'hCD;
    localparam logic [7:0] LEVEL_BRIGHT = 8'hFF;

    typedef struct packed {
        logic [7:0] bits;
        logic [3:0] ink;
        logic [3:0] paper;
    } t_cell;

    typedef struct packed {
        logic       colour_mode;
        logic       red_high;
    } t_cfg;

    function automatic logic [23:0] colour_rgb(input logic [3:0] idx, input logic red_high);
        logic [7:0] level;
        logic [7:0] blue;
        logic [7:0] red;
        logic [7:0] green;
        level = idx[3] ? LEVEL_BRIGHT : LEVEL_NORMAL;
        blue  = idx[0] ? level : 8'h00;
        red   = idx[1] ? level : 8'h00;
        green = idx[2] ? level : 8'h00;
        return red_high ? {red, green, blue} : {blue, green, red};
    endfunction

endpackage

// ===== rtl/core/acpe_pixel_fmt.sv =====
// Formatter: builds one result word from a latched cell and a pixel position.
`timescale 1ns / 1ps

module acpe_pixel_fmt
    import acpe_pkg::*;
(
    input  t_cell       i_cell,
    input  logic [2:0]  i_pix,
    input  t_cfg        i_cfg,
    output logic [31:0] o_word
);

    logic [31:0] packed_word;
    logic        sel;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            packed_word[4*k +: 4] = i_cell.bits[7-k] ? i_cell.ink : i_cell.paper;
        end
    end

    assign sel = i_cell.bits[3'd7 - i_pix];

    always_comb begin
        if (i_cfg.colour_mode) begin
            o_word = {8'h00, colour_rgb(sel ? i_cell.ink : i_cell.paper, i_cfg.red_high)};
        end else begin
            o_word = packed_word;
        end
    end

endmodule

// ===== rtl/core/attribute_cell_pixel_expander.sv =====
// Top level: attribute cell to pixel expander with cell register and result register.
// An accepted cell is latched in the cell register, then its first result in the result register.
// Throughput: packed mode takes a cell every cycle; colour mode stays busy until the last pixel,
// set by the single pixel formatter stepping one pixel per cycle out of the cell register.
// Results are strobed for one cycle each; the receiver cannot stall.
// Reset (synchronous, active low) clears both configuration registers and all strobes.
`timescale 1ns / 1ps

module attribute_cell_pixel_expander
    import acpe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [7:0]           i_bitmap_byte,
    input  logic [7:0]           i_attribute_byte,
    output logic                 o_strobe,
    output logic [31:0]          o_pixel_word,
    output logic                 o_last
);

    t_cfg        r_cfg;
    t_cell       r_cell;
    logic        r_active;
    logic [2:0]  r_pix;
    logic        r_strobe;
    logic [31:0] r_word;
    logic        r_last;

    logic        accept;
    logic        cell_done;
    logic [31:0] fmt_word;

    assign cell_done = !r_cfg.colour_mode || (r_pix == 3'd7);
    assign o_busy    = r_active && !cell_done;
    assign accept    = i_start && !o_busy;

    acpe_pixel_fmt u_fmt (
        .i_cell (r_cell),
        .i_pix  (r_pix),
        .i_cfg  (r_cfg),
        .o_word (fmt_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OUTPUT_MODE:   r_cfg.colour_mode <= i_cfg_data;
                CFG_CHANNEL_ORDER: r_cfg.red_high    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pix    <= 3'd0;
        end else if (accept) begin
            r_active <= 1'b1;
            r_pix    <= 3'd0;
        end else if (r_active) begin
            if (cell_done) begin
                r_active <= 1'b0;
            end else begin
                r_pix <= r_pix + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cell.bits  <= i_bitmap_byte;
            r_cell.ink   <= {i_attribute_byte[6], i_attribute_byte[2:0]};
            r_cell.paper <= {i_attribute_byte[6], i_attribute_byte[5:3]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= fmt_word;
        r_last <= cell_done;
    end

    assign o_strobe     = r_strobe;
    assign o_pixel_word = r_word;
    assign o_last       = r_last;

`ifndef ASSERT_OFF
    a_accept_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##2 o_strobe)
        else $error("accepted cell produced no result beat");

    a_busy_streams: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |=> o_strobe && !o_last)
        else $error("colour cell stream broke or ended early");

    a_packed_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !r_cfg.colour_mode) |-> o_last)
        else $error("packed beat without last");

    a_colour_last_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last && r_cfg.colour_mode) |-> $past(o_busy, 2))
        else $error("colour last beat not preceded by a busy cell");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench: directed and random cells through the pixel expander, every result beat checked.
module tb;
    import acpe_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int N_PHASES    = 5;
    localparam int PHASE_CELLS = 86;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } t_pixel_beat;

    class cell_pixel_checker;
        t_pixel_beat expected_pixels[$];
        logic        colour_mode;
        logic        red_high;
        int          fails;
        int          cells;
        int          beats;

        function new();
            colour_mode = 1'b0;
            red_high    = 1'b0;
            fails       = 0;
            cells       = 0;
            beats       = 0;
        endfunction

        function void set_cfg(logic [CFG_IDX_W-1:0] idx, logic val);
            if (idx == CFG_OUTPUT_MODE) begin
                colour_mode = val;
            end else if (idx == CFG_CHANNEL_ORDER) begin
                red_high = val;
            end
        endfunction

        function logic [23:0] channel_rgb(logic [3:0] idx);
            logic [7:0] lvl;
            logic [7:0] blu;
            logic [7:0] red;
            logic [7:0] grn;
            lvl = idx[3] ? LEVEL_BRIGHT : LEVEL_NORMAL;
            blu = idx[0] ? lvl : 8'h00;
            red = idx[1] ? lvl : 8'h00;
            grn = idx[2] ? lvl : 8'h00;
            if (red_high) begin
                return {red, grn, blu};
            end
            return {blu, grn, red};
        endfunction

        // flash (attr bit 7) never reaches the pixel
        function void note_cell(logic [7:0] bits, logic [7:0] attr);
            logic [3:0]  ink;
            logic [3:0]  paper;
            logic [3:0]  pix;
            t_pixel_beat beat;
            ink   = {attr[6], attr[2:0]};
            paper = {attr[6], attr[5:3]};
            cells++;
            if (!colour_mode) begin
                beat.word = '0;
                for (int k = 0; k < 8; k++) begin
                    beat.word[4*k +: 4] = bits[7-k] ? ink : paper;
                end
                beat.last = 1'b1;
                expected_pixels.push_back(beat);
            end else begin
                for (int k = 0; k < 8; k++) begin
                    pix       = bits[7-k] ? ink : paper;
                    beat.word = {8'h00, channel_rgb(pix)};
                    beat.last = (k == 7);
                    expected_pixels.push_back(beat);
                end
            end
        endfunction

        function void check_pixel(logic [31:0] word, logic last);
            t_pixel_beat want;
            beats++;
            if (expected_pixels.size() == 0) begin
                fails++;
                if (fails <= 10) begin
                    $display("unexpected beat: word=%08h last=%0b", word, last);
                end
            end else begin
                want = expected_pixels.pop_front();
                if (word !== want.word || last !== want.last) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("mismatch beat %0d: exp word=%08h last=%0b, got word=%08h last=%0b",
                                 beats, want.word, want.last, word, last);
                    end
                end
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic                 i_cfg_data;
    logic                 i_start;
    logic                 o_busy;
    logic [7:0]           i_bitmap_byte;
    logic [7:0]           i_attribute_byte;
    logic                 o_strobe;
    logic [31:0]          o_pixel_word;
    logic                 o_last;

    cell_pixel_checker sb;
    int                cycles;

    attribute_cell_pixel_expander u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_bitmap_byte    (i_bitmap_byte),
        .i_attribute_byte (i_attribute_byte),
        .o_strobe         (o_strobe),
        .o_pixel_word     (o_pixel_word),
        .o_last           (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_start && !o_busy) begin
                sb.note_cell(i_bitmap_byte, i_attribute_byte);
            end
            if (o_strobe) begin
                sb.check_pixel(o_pixel_word, o_last);
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("tb NOT OK");
        $finish;
    end

    task automatic send_cell(input logic [7:0] bits, input logic [7:0] attr);
        i_start          <= 1'b1;
        i_bitmap_byte    <= bits;
        i_attribute_byte <= attr;
        @(posedge i_clk);
        while (o_busy) begin
            @(posedge i_clk);
        end
    endtask

    task automatic rest(input int n);
        i_start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_cfg(input logic mode, input logic order);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_OUTPUT_MODE;
        i_cfg_data  <= mode;
        @(posedge i_clk);
        sb.set_cfg(CFG_OUTPUT_MODE, mode);
        i_cfg_index <= CFG_CHANNEL_ORDER;
        i_cfg_data  <= order;
        @(posedge i_clk);
        sb.set_cfg(CFG_CHANNEL_ORDER, order);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic directed_cells();
        logic [7:0] bits_list [12];
        logic [7:0] attr_list [12];
        bits_list = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55,
                      8'h0F, 8'hF0, 8'h81, 8'h7E, 8'hC3, 8'h3C};
        attr_list = '{8'h00, 8'hFF, 8'h07, 8'h38, 8'h47, 8'h78,
                      8'hC0, 8'hBF, 8'h80, 8'h7F, 8'h3F, 8'h40};
        for (int i = 0; i < 12; i++) begin
            send_cell(bits_list[i], attr_list[i]);
        end
    endtask

    task automatic random_cells(input int n);
        int         left;
        int         burst;
        logic [7:0] bits;
        logic [7:0] attr;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 12);
            if (burst > left) begin
                burst = left;
            end
            repeat (burst) begin
                case ($urandom_range(0, 9))
                    0:       bits = 8'h00;
                    1:       bits = 8'hFF;
                    default: bits = 8'($urandom);
                endcase
                attr = 8'($urandom);
                send_cell(bits, attr);
            end
            left -= burst;
            if ($urandom_range(0, 19) == 0) begin
                drain();
            end else if ($urandom_range(0, 2) != 0) begin
                rest($urandom_range(1, 7));
            end
        end
    endtask

    initial begin
        logic phase_mode  [N_PHASES];
        logic phase_order [N_PHASES];
        phase_mode  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
        phase_order = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
        sb               = new();
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = CFG_OUTPUT_MODE;
        i_cfg_data       = 1'b0;
        i_start          = 1'b0;
        i_bitmap_byte    = 8'h00;
        i_attribute_byte = 8'h00;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset state: packed, blue high
        directed_cells();
        drain();
        apply_cfg(1'b1, 1'b0);
        directed_cells();
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            apply_cfg(phase_mode[p], phase_order[p]);
            random_cells(PHASE_CELLS);
            drain();
        end

        repeat (16) @(posedge i_clk);
        $display("%0d cells accepted, %0d result beats checked", sb.cells, sb.beats);
        $display("packed and colour modes, both channel orders, bursts, gaps and full drains");
        if (sb.fails == 0 && sb.expected_pixels.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("%0d failures", sb.fails + sb.expected_pixels.size());
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== attribute_cell_pixel_expander.f =====
rtl/core/acpe_pkg.sv
rtl/core/acpe_pixel_fmt.sv
rtl/core/attribute_cell_pixel_expander.sv
tb/tb.sv
